>>> design/bvd_pkg.sv
// ----------------------------------------------------------------------------
// bvd_pkg
// Types, widths and constants shared by the byte-vertical delta decoder.
// ----------------------------------------------------------------------------
package bvd_pkg;

  // Payload widths
  localparam int unsigned ByteW   = 8;
  localparam int unsigned PlaneW  = 3;
  localparam int unsigned ColOutW = 10;
  localparam int unsigned RowOutW = 10;
  localparam int unsigned RunW    = 8;
  localparam int unsigned LitW    = 7;
  localparam int unsigned CfgW    = 11;  // columns / rows register width
  localparam int unsigned PosW    = 11;  // current column / row counters
  localparam int unsigned CapW    = 13;  // wide enough for the parameter caps
  localparam int unsigned CfgIdxW = 4;

  // Parameter defaults
  localparam int unsigned DefMaxColumns = 1024;
  localparam int unsigned DefMaxRows    = 1024;
  localparam int unsigned DefMaxPlanes  = 8;

  // Register reset values
  localparam logic [CfgW-1:0] ColumnsRst = CfgW'(40);
  localparam logic [CfgW-1:0] RowsRst    = CfgW'(200);

  // Register indexes
  localparam logic [CfgIdxW-1:0] CfgIdxColumns = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CfgIdxRows    = CfgIdxW'(1);

  // Op byte decoding
  localparam logic [ByteW-1:0] OpUniqueBit = 8'h80;
  localparam logic [ByteW-1:0] OpLenMask   = 8'h7F;
  localparam logic [PosW-1:0]  RowSat      = PosW'(2047);

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_COUNT = 3'd1,
    PH_OP    = 3'd2,
    PH_LIT   = 3'd3,
    PH_FCNT  = 3'd4,
    PH_FVAL  = 3'd5
  } phase_e;

  typedef struct packed {
    logic [PlaneW-1:0]  plane;
    logic [ColOutW-1:0] column;
    logic [RowOutW-1:0] first_row;
    logic [RunW-1:0]    run_rows;
    logic [ByteW-1:0]   value;
  } cmd_t;

  typedef struct packed {
    logic [CfgW-1:0] columns;
    logic [CfgW-1:0] rows;
  } cfg_t;

endpackage

>>> design/bvd_if.sv
// ----------------------------------------------------------------------------
// bvd_if
// Valid/ready channels of the decoder: op bytes in, write commands out,
// register writes.
// ----------------------------------------------------------------------------
interface bvd_in_if;
  import bvd_pkg::*;
  logic              valid;
  logic              ready;
  logic [ByteW-1:0]  op_byte;
  logic              plane_start;
  logic [PlaneW-1:0] plane_index;

  modport source (output valid, output op_byte, output plane_start, output plane_index,
                  input ready);
  modport sink   (input valid, input op_byte, input plane_start, input plane_index,
                  output ready);
endinterface

interface bvd_out_if;
  import bvd_pkg::*;
  logic               valid;
  logic               ready;
  logic [PlaneW-1:0]  plane;
  logic [ColOutW-1:0] column;
  logic [RowOutW-1:0] first_row;
  logic [RunW-1:0]    run_rows;
  logic [ByteW-1:0]   value;

  modport source (output valid, output plane, output column, output first_row,
                  output run_rows, output value, input ready);
  modport sink   (input valid, input plane, input column, input first_row,
                  input run_rows, input value, output ready);
endinterface

interface bvd_cfg_if;
  import bvd_pkg::*;
  logic               valid;
  logic               ready;
  logic [CfgIdxW-1:0] index;
  logic [CfgW-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

>>> design/bvd_cfg_regs.sv
// ----------------------------------------------------------------------------
// bvd_cfg_regs
// Columns and rows registers, written through the register channel.
// ----------------------------------------------------------------------------
module bvd_cfg_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        wr_i,
  input  logic [bvd_pkg::CfgIdxW-1:0] idx_i,
  input  logic [bvd_pkg::CfgW-1:0]    data_i,
  output bvd_pkg::cfg_t               cfg_o
);
  import bvd_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_i) begin
      if (idx_i == CfgIdxColumns) begin
        cfg_d.columns = data_i;
      end else if (idx_i == CfgIdxRows) begin
        cfg_d.rows = data_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.columns <= ColumnsRst;
      cfg_q.rows    <= RowsRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> design/bvd_parse.sv
// ----------------------------------------------------------------------------
// bvd_parse
// Op list parser: phase and position registers, one byte per transfer,
// at most one write command out.
// ----------------------------------------------------------------------------
module bvd_parse #(
  parameter int unsigned MAX_COLUMNS = bvd_pkg::DefMaxColumns,
  parameter int unsigned MAX_ROWS    = bvd_pkg::DefMaxRows,
  parameter int unsigned MAX_PLANES  = bvd_pkg::DefMaxPlanes
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       fire_i,
  input  logic [bvd_pkg::ByteW-1:0]  op_byte_i,
  input  logic                       plane_start_i,
  input  logic [bvd_pkg::PlaneW-1:0] plane_index_i,
  input  bvd_pkg::cfg_t              cfg_i,
  output logic                       cmd_valid_o,
  output bvd_pkg::cmd_t              cmd_o
);
  import bvd_pkg::*;

  localparam logic [CapW-1:0]     MaxColsC   = CapW'(MAX_COLUMNS);
  localparam logic [CapW-1:0]     MaxRowsC   = CapW'(MAX_ROWS);
  localparam logic [PlaneW:0]     MaxPlanesC = (PlaneW+1)'(MAX_PLANES);

  phase_e             phase_q, phase_d;
  logic [ByteW-1:0]   ops_q, ops_d;
  logic [LitW-1:0]    lit_q, lit_d;
  logic [ByteW-1:0]   fcnt_q, fcnt_d;
  logic [PosW-1:0]    col_q, col_d;
  logic [PosW-1:0]    row_q, row_d;
  logic [PlaneW-1:0]  plane_q, plane_d;

  logic [PosW-1:0]    eff_cols, eff_rows;
  logic [PosW-1:0]    room;
  logic [PosW:0]      skip_sum;
  logic [PosW-1:0]    col_inc;
  logic [ByteW-1:0]   ops_dec;
  logic [RunW-1:0]    run;
  logic               end_op, end_col;

  // Caps are at most the register value here, so the low bits hold the result
  assign eff_cols = ({2'b00, cfg_i.columns} > MaxColsC) ? MaxColsC[PosW-1:0] : cfg_i.columns;
  assign eff_rows = ({2'b00, cfg_i.rows} > MaxRowsC) ? MaxRowsC[PosW-1:0] : cfg_i.rows;

  always_comb begin
    phase_d     = phase_q;
    ops_d       = ops_q;
    lit_d       = lit_q;
    fcnt_d      = fcnt_q;
    col_d       = col_q;
    row_d       = row_q;
    plane_d     = plane_q;
    end_op      = 1'b0;
    end_col     = 1'b0;
    cmd_valid_o = 1'b0;
    run         = RunW'(1);
    room        = '0;
    skip_sum    = '0;
    col_inc     = '0;
    ops_dec     = '0;

    // Plane start restarts the list; an out-of-range plane is dropped
    if (plane_start_i) begin
      ops_d  = '0;
      lit_d  = '0;
      fcnt_d = '0;
      col_d  = '0;
      row_d  = '0;
      if ({1'b0, plane_index_i} >= MaxPlanesC) begin
        phase_d = PH_IDLE;
      end else begin
        plane_d = plane_index_i;
        phase_d = PH_COUNT;
      end
    end

    if (!(plane_start_i && ({1'b0, plane_index_i} >= MaxPlanesC))) begin
      case (phase_d)
        PH_COUNT: begin
          ops_d = op_byte_i;
          if (op_byte_i == '0) begin
            end_col = 1'b1;
          end else begin
            phase_d = PH_OP;
          end
        end
        PH_OP: begin
          if ((op_byte_i & OpUniqueBit) != '0) begin
            lit_d = LitW'(op_byte_i & OpLenMask);
            if ((op_byte_i & OpLenMask) == '0) begin
              end_op = 1'b1;
            end else begin
              phase_d = PH_LIT;
            end
          end else if (op_byte_i == '0) begin
            phase_d = PH_FCNT;
          end else begin
            skip_sum = {1'b0, row_d} + (PosW+1)'(op_byte_i);
            row_d    = skip_sum[PosW] ? RowSat : skip_sum[PosW-1:0];
            end_op   = 1'b1;
          end
        end
        PH_LIT: begin
          if (row_d < eff_rows) begin
            cmd_valid_o = 1'b1;
            run         = RunW'(1);
            row_d       = row_d + PosW'(1);
          end
          if (lit_d != '0) begin
            lit_d = lit_d - LitW'(1);
          end
          if (lit_d == '0) begin
            end_op = 1'b1;
          end
        end
        PH_FCNT: begin
          fcnt_d  = op_byte_i;
          phase_d = PH_FVAL;
        end
        PH_FVAL: begin
          if (fcnt_d != '0 && row_d < eff_rows) begin
            room        = eff_rows - row_d;
            run         = ({3'b000, fcnt_d} < room) ? fcnt_d : room[RunW-1:0];
            cmd_valid_o = 1'b1;
          end
          fcnt_d = '0;
          end_op = 1'b1;
        end
        default: begin
          phase_d = PH_IDLE;
        end
      endcase
    end

    // Command fields use the row before this byte's advance
    cmd_o.plane     = plane_d;
    cmd_o.column    = col_d[ColOutW-1:0];
    cmd_o.first_row = row_d[RowOutW-1:0];
    cmd_o.run_rows  = run;
    cmd_o.value     = op_byte_i;
    if (phase_q != PH_IDLE || plane_start_i) begin
      if (cmd_valid_o && (phase_d == PH_LIT)) begin
        cmd_o.first_row = RowOutW'(row_d - PosW'(1));
      end
    end
    if (cmd_valid_o && (phase_d == PH_FVAL)) begin
      row_d = row_d + PosW'(run);
    end

    if (end_op) begin
      ops_dec = (ops_d != '0) ? ops_d - ByteW'(1) : '0;
      ops_d   = ops_dec;
      if (ops_dec == '0) begin
        end_col = 1'b1;
      end else begin
        phase_d = PH_OP;
      end
    end
    if (end_col) begin
      col_inc = col_d + PosW'(1);
      col_d   = col_inc;
      row_d   = '0;
      phase_d = (col_inc >= eff_cols) ? PH_IDLE : PH_COUNT;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      ops_q   <= '0;
      lit_q   <= '0;
      fcnt_q  <= '0;
      col_q   <= '0;
      row_q   <= '0;
      plane_q <= '0;
    end else if (fire_i) begin
      phase_q <= phase_d;
      ops_q   <= ops_d;
      lit_q   <= lit_d;
      fcnt_q  <= fcnt_d;
      col_q   <= col_d;
      row_q   <= row_d;
      plane_q <= plane_d;
    end
  end

endmodule

>>> design/bvd_skid.sv
// ----------------------------------------------------------------------------
// bvd_skid
// Output register plus skid entry; input ready comes from a flop.
// ----------------------------------------------------------------------------
module bvd_skid (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  bvd_pkg::cmd_t cmd_i,
  output logic          ready_o,
  output logic          valid_o,
  input  logic          ready_i,
  output bvd_pkg::cmd_t cmd_o
);
  import bvd_pkg::*;

  logic out_valid_q, out_valid_d;
  logic skid_valid_q, skid_valid_d;
  cmd_t out_q, out_d;
  cmd_t skid_q, skid_d;
  logic slot_free;

  assign slot_free = !out_valid_q || ready_i;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (slot_free) begin
      if (skid_valid_q) begin
        out_d        = skid_q;
        out_valid_d  = 1'b1;
        skid_valid_d = push_i;
        if (push_i) begin
          skid_d = cmd_i;
        end
      end else begin
        out_valid_d = push_i;
        if (push_i) begin
          out_d = cmd_i;
        end
      end
    end else if (push_i) begin
      skid_d       = cmd_i;
      skid_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign ready_o = !skid_valid_q;
  assign valid_o = out_valid_q;
  assign cmd_o   = out_q;

endmodule

>>> design/byte_vertical_delta_decode.sv
// ----------------------------------------------------------------------------
// byte_vertical_delta_decode
// Byte-vertical delta op list decoder: one op byte per transfer in, at most
// one clipped write command (plane, column, first row, row count, value) out.
// ----------------------------------------------------------------------------
// Usage:
//   in_if  : op list bytes; plane_start marks the column 0 op count of a new
//            plane and carries its plane_index. A transfer is taken every
//            cycle while ready is high.
//   out_if : write commands, valid/ready. A byte's command is registered in
//            the output register or skid entry; most bytes cause none.
//   cfg_if : columns (index 0) and rows (index 1); always ready. Write only
//            between bytes with no command in flight; the new value applies
//            from the next byte, also in the middle of a plane.
//   Throughput is one byte per cycle while ready is high; the parser update
//   between the parser registers and the output register is combinational.
//   When the receiver stalls, the output register holds its command and one
//   more command lands in the skid entry; ready then drops until the skid
//   entry drains, so nothing is lost.
//   Reset (rst_ni low, asynchronous) empties both output entries, puts the
//   parser in the plane-done state and loads columns = 40, rows = 200.
// ----------------------------------------------------------------------------
module byte_vertical_delta_decode #(
  parameter int unsigned MAX_COLUMNS = bvd_pkg::DefMaxColumns,
  parameter int unsigned MAX_ROWS    = bvd_pkg::DefMaxRows,
  parameter int unsigned MAX_PLANES  = bvd_pkg::DefMaxPlanes
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  bvd_in_if.sink    in_if,
  bvd_out_if.source out_if,
  bvd_cfg_if.sink   cfg_if
);
  import bvd_pkg::*;

  cfg_t cfg;
  cmd_t parse_cmd;
  cmd_t out_cmd;
  logic parse_cmd_valid;
  logic in_ready;
  logic in_fire;

  // Register writes are always accepted
  assign cfg_if.ready = 1'b1;

  bvd_cfg_regs u_cfg_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_i   (cfg_if.valid),
    .idx_i  (cfg_if.index),
    .data_i (cfg_if.data),
    .cfg_o  (cfg)
  );

  // Parser state advances only on an input transfer
  assign in_fire     = in_if.valid && in_ready;
  assign in_if.ready = in_ready;

  bvd_parse #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_ROWS    (MAX_ROWS),
    .MAX_PLANES  (MAX_PLANES)
  ) u_parse (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .fire_i        (in_fire),
    .op_byte_i     (in_if.op_byte),
    .plane_start_i (in_if.plane_start),
    .plane_index_i (in_if.plane_index),
    .cfg_i         (cfg),
    .cmd_valid_o   (parse_cmd_valid),
    .cmd_o         (parse_cmd)
  );

  // Output register with one skid entry
  bvd_skid u_skid (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (in_fire && parse_cmd_valid),
    .cmd_i   (parse_cmd),
    .ready_o (in_ready),
    .valid_o (out_if.valid),
    .ready_i (out_if.ready),
    .cmd_o   (out_cmd)
  );

  assign out_if.plane     = out_cmd.plane;
  assign out_if.column    = out_cmd.column;
  assign out_if.first_row = out_cmd.first_row;
  assign out_if.run_rows  = out_cmd.run_rows;
  assign out_if.value     = out_cmd.value;

endmodule
